FILE: rtl/wsp_pkg.sv
package wsp_pkg;

  localparam int RegCount = 8;
  localparam int AddrW = 6;
  localparam int DataW = 64;
  localparam int SizeW = 14;
  localparam int ClipW = 50;
  localparam int NumW = 64;
  localparam int RemW = 49;
  localparam int QuoW = 33;
  localparam int FracW = 15;
  localparam int DivStages = QuoW;
  localparam int Latency = DivStages + 5;

  localparam logic signed [ClipW-1:0] WMin = 50'sd656;
  localparam logic [SizeW-1:0] WidthReset = 14'd1920;
  localparam logic [SizeW-1:0] HeightReset = 14'd1080;

  typedef enum logic [2:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW3_C01 = 3'd4,
    REG_ROW3_C23 = 3'd5,
    REG_WIDTH    = 3'd6,
    REG_HEIGHT   = 3'd7
  } wsp_reg_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } wsp_point_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               visible;
  } wsp_pixel_t;

  typedef struct packed {
    logic [5:0][DataW-1:0] mat;
    logic [SizeW-1:0]      width;
    logic [SizeW-1:0]      height;
  } wsp_cfg_t;

  typedef struct packed {
    logic                   valid;
    logic                   vis;
    logic signed [NumW-1:0] num_x;
    logic signed [NumW-1:0] num_y;
    logic [RemW-1:0]        w;
  } wsp_clip_t;

  typedef struct packed {
    logic            valid;
    logic            tag;
    logic            neg;
    logic            ovf;
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] low;
    logic [QuoW-1:0] quo;
    logic [RemW-1:0] div;
  } wsp_div_stage_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/wsp_regs.sv
module wsp_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsp_pkg::AddrW-1:0]   paddr,
  input  logic [wsp_pkg::DataW-1:0]   pwdata,
  output logic [wsp_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output wsp_pkg::wsp_cfg_t           cfg
);

  wsp_pkg::wsp_reg_t sel;
  logic              wr;

  assign sel = wsp_pkg::wsp_reg_t'(paddr[5:3]);
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mat <= '0;
      cfg.width <= wsp_pkg::WidthReset;
      cfg.height <= wsp_pkg::HeightReset;
    end else if (wr) begin
      case (sel)
        wsp_pkg::REG_WIDTH: cfg.width <= pwdata[wsp_pkg::SizeW-1:0];
        wsp_pkg::REG_HEIGHT: cfg.height <= pwdata[wsp_pkg::SizeW-1:0];
        default: cfg.mat[sel] <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (sel)
      wsp_pkg::REG_WIDTH: prdata = 64'(cfg.width);
      wsp_pkg::REG_HEIGHT: prdata = 64'(cfg.height);
      default: prdata = cfg.mat[sel];
    endcase
  end

endmodule

FILE: rtl/wsp_clip.sv
module wsp_clip (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  wsp_pkg::wsp_point_t point,
  input  wsp_pkg::wsp_cfg_t   cfg,
  output wsp_pkg::wsp_clip_t  out
);

  logic signed [31:0] pt [3];
  logic signed [63:0] prod [3][3];
  logic signed [wsp_pkg::ClipW-1:0] clip [3];
  logic v1, v2;

  assign pt[0] = point.world_x;
  assign pt[1] = point.world_y;
  assign pt[2] = point.world_z;

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [31:0] m3;
    logic signed [65:0] sum;
    logic signed [wsp_pkg::ClipW-1:0] clip_next;

    assign m3 = signed'(cfg.mat[2*r+1][63:32]);

    for (genvar i = 0; i < 3; i++) begin : g_col
      logic signed [63:0] m;
      logic signed [63:0] p;
      assign m = signed'(cfg.mat[2*r + i/2][32*(i%2) +: 32]);
      assign p = pt[i];
      always_ff @(posedge clk) begin
        prod[r][i] <= m * p;
      end
    end

    assign sum = 66'(prod[r][0]) + 66'(prod[r][1]) + 66'(prod[r][2]);
    assign clip_next = wsp_pkg::ClipW'(sum >>> 16) + wsp_pkg::ClipW'(m3);

    always_ff @(posedge clk) begin
      clip[r] <= clip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out.valid <= v2;
    end
    out.num_x <= clip[0] * signed'({1'b0, cfg.width});
    out.num_y <= clip[1] * signed'({1'b0, cfg.height});
    out.vis <= clip[2] >= wsp_pkg::WMin;
    out.w <= clip[2][wsp_pkg::RemW-1:0];
  end

endmodule

FILE: rtl/wsp_div.sv
module wsp_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_tag,
  input  logic signed [wsp_pkg::NumW-1:0]    num,
  input  logic [wsp_pkg::RemW-1:0]           w,
  output wsp_pkg::wsp_div_stage_t            out
);

  localparam int DW = wsp_pkg::NumW - 1 + wsp_pkg::FracW;

  wsp_pkg::wsp_div_stage_t st [wsp_pkg::DivStages+1];
  logic                    neg;
  logic [wsp_pkg::NumW-2:0] mag;
  logic [DW-1:0]           dvd;

  assign neg = num[wsp_pkg::NumW-1];
  assign mag = neg ? ~num[wsp_pkg::NumW-2:0] : num[wsp_pkg::NumW-2:0];
  assign dvd = {mag, neg ? {wsp_pkg::FracW{1'b1}} : {wsp_pkg::FracW{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else begin
      st[0].valid <= in_valid;
    end
    st[0].tag <= in_tag;
    st[0].neg <= neg;
    st[0].ovf <= wsp_pkg::RemW'(dvd[DW-1:wsp_pkg::QuoW]) >= w;
    st[0].rem <= wsp_pkg::RemW'(dvd[DW-1:wsp_pkg::QuoW]);
    st[0].low <= dvd[wsp_pkg::QuoW-1:0];
    st[0].quo <= '0;
    st[0].div <= w;
  end

  for (genvar k = 1; k <= wsp_pkg::DivStages; k++) begin : g_stage
    logic [wsp_pkg::RemW:0] shifted;
    logic [wsp_pkg::RemW:0] diff;
    logic                   take;

    assign shifted = {st[k-1].rem, st[k-1].low[wsp_pkg::QuoW-1]};
    assign diff = shifted - {1'b0, st[k-1].div};
    assign take = shifted >= {1'b0, st[k-1].div};

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k].valid <= 1'b0;
      end else begin
        st[k].valid <= st[k-1].valid;
      end
      st[k].tag <= st[k-1].tag;
      st[k].neg <= st[k-1].neg;
      st[k].ovf <= st[k-1].ovf;
      st[k].rem <= take ? diff[wsp_pkg::RemW-1:0] : shifted[wsp_pkg::RemW-1:0];
      st[k].low <= {st[k-1].low[wsp_pkg::QuoW-2:0], 1'b0};
      st[k].quo <= {st[k-1].quo[wsp_pkg::QuoW-2:0], take};
      st[k].div <= st[k-1].div;
    end
  end

  assign out = st[wsp_pkg::DivStages];

endmodule

FILE: rtl/world_to_screen_projection.sv
// Projects one world point per transaction to window-relative screen coordinates.
// A transaction is taken in every cycle in which start is high (busy stays low), and
// its result appears on pixel with done high for one cycle, in order. The pipeline
// has three multiply and sum stages, one divider set-up stage, 33 one-bit divider
// stages and one output stage. The receiver cannot stall the block, so every result
// must be captured in the cycle in which done is high.
module world_to_screen_projection (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  wsp_pkg::wsp_point_t              point,
  output logic                             done,
  output wsp_pkg::wsp_pixel_t              pixel,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wsp_pkg::AddrW-1:0]        paddr,
  input  logic [wsp_pkg::DataW-1:0]        pwdata,
  output logic [wsp_pkg::DataW-1:0]        prdata,
  output logic                             pready
);

  wsp_pkg::wsp_cfg_t       cfg;
  wsp_pkg::wsp_clip_t      clip;
  wsp_pkg::wsp_div_stage_t dx;
  wsp_pkg::wsp_div_stage_t dy;
  logic signed [35:0]      qx;
  logic signed [35:0]      qy;
  logic signed [35:0]      sx;
  logic signed [35:0]      sy;
  wsp_pkg::wsp_pixel_t     pixel_next;

  assign busy = 1'b0;

  wsp_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  wsp_clip u_clip (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .point(point), .cfg(cfg),
    .out(clip)
  );

  wsp_div u_div_x (
    .clk(clk), .rst(rst), .in_valid(clip.valid), .in_tag(clip.vis),
    .num(clip.num_x), .w(clip.w), .out(dx)
  );

  wsp_div u_div_y (
    .clk(clk), .rst(rst), .in_valid(clip.valid), .in_tag(clip.vis),
    .num(clip.num_y), .w(clip.w), .out(dy)
  );

  assign qx = dx.neg ? signed'(~{3'b000, dx.quo}) : signed'({3'b000, dx.quo});
  assign qy = dy.neg ? signed'(~{3'b000, dy.quo}) : signed'({3'b000, dy.quo});
  assign sx = signed'(36'({cfg.width[wsp_pkg::SizeW-1:1], 1'b1, 15'h0000})) + qx;
  assign sy = signed'(36'({cfg.height[wsp_pkg::SizeW-1:1], 16'h0000}))
              - 36'sd32768 - qy;

  always_comb begin
    pixel_next.visible = dx.tag;
    if (!dx.tag) begin
      pixel_next.screen_x = '0;
    end else if (dx.ovf) begin
      pixel_next.screen_x = dx.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      pixel_next.screen_x = wsp_pkg::sat32(sx);
    end
    if (!dx.tag) begin
      pixel_next.screen_y = '0;
    end else if (dy.ovf) begin
      pixel_next.screen_y = dy.neg ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    end else begin
      pixel_next.screen_y = wsp_pkg::sat32(sy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dx.valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel <= pixel_next;
  end

`ifndef ASSERT_OFF
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    done && !pixel.visible |-> pixel.screen_x == 32'sd0 && pixel.screen_y == 32'sd0)
    else $error("hidden point with nonzero coordinates");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, wsp_pkg::Latency))
    else $error("result without a matching transaction");

  a_lanes: assert property (@(posedge clk) disable iff (rst)
    dx.valid == dy.valid && (!dx.valid || dx.tag == dy.tag))
    else $error("divider lanes out of step");
`endif

endmodule

FILE: tb/tb_world_to_screen_projection.sv
`timescale 1ns / 100ps
module tb_world_to_screen_projection;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  wsp_pkg::wsp_point_t point;
  logic done;
  wsp_pkg::wsp_pixel_t pixel;
  logic psel;
  logic penable;
  logic pwrite;
  logic [wsp_pkg::AddrW-1:0] paddr;
  logic [wsp_pkg::DataW-1:0] pwdata;
  logic [wsp_pkg::DataW-1:0] prdata;
  logic pready;

  world_to_screen_projection u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .pixel(pixel), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  logic [wsp_pkg::DataW-1:0] shadow_regs [wsp_pkg::RegCount];
  wsp_pkg::wsp_point_t pending_points [$];
  wsp_pkg::wsp_pixel_t expected_pixels [$];
  int errors;
  int send_idle_pct;
  logic took;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("FAIL world_to_screen_projection");
    $finish;
  end

  function automatic logic signed [127:0] floor_div(logic signed [127:0] n,
                                                    logic signed [127:0] d);
    logic signed [127:0] q;
    q = n / d;
    if (q * d > n) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [127:0] clip_value(logic [63:0] c01, logic [63:0] c23,
                                                     wsp_pkg::wsp_point_t p);
    logic signed [127:0] m0, m1, m2, m3, px, py, pz, s;
    m0 = $signed(c01[31:0]);
    m1 = $signed(c01[63:32]);
    m2 = $signed(c23[31:0]);
    m3 = $signed(c23[63:32]);
    px = p.world_x;
    py = p.world_y;
    pz = p.world_z;
    s = m0 * px + m1 * py + m2 * pz;
    return (s >>> 16) + m3;
  endfunction

  function automatic logic signed [127:0] scaled_div(logic signed [127:0] c,
                                                     logic signed [127:0] size,
                                                     logic signed [127:0] w);
    logic signed [127:0] num, q1, r, lim;
    lim = 128'sd1 <<< 34;
    num = c * size;
    q1 = floor_div(num, w);
    r = num - q1 * w;
    if (q1 > lim) q1 = lim;
    if (q1 < -lim) q1 = -lim;
    return q1 * 32768 + (r * 32768) / w;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -128'sh8000_0000) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic wsp_pkg::wsp_pixel_t project_point(wsp_pkg::wsp_point_t p);
    wsp_pkg::wsp_pixel_t r;
    logic signed [127:0] cx, cy, w, wd, ht, sx, sy;
    cx = clip_value(shadow_regs[wsp_pkg::REG_ROW0_C01], shadow_regs[wsp_pkg::REG_ROW0_C23], p);
    cy = clip_value(shadow_regs[wsp_pkg::REG_ROW1_C01], shadow_regs[wsp_pkg::REG_ROW1_C23], p);
    w = clip_value(shadow_regs[wsp_pkg::REG_ROW3_C01], shadow_regs[wsp_pkg::REG_ROW3_C23], p);
    r = '0;
    if (w < 656) return r;
    wd = shadow_regs[wsp_pkg::REG_WIDTH][wsp_pkg::SizeW-1:0];
    ht = shadow_regs[wsp_pkg::REG_HEIGHT][wsp_pkg::SizeW-1:0];
    sx = (wd / 2) * 65536 + 32768 + scaled_div(cx, wd, w);
    sy = (ht / 2) * 65536 - 32768 - scaled_div(cy, ht, w);
    r.screen_x = clamp32(sx);
    r.screen_y = clamp32(sy);
    r.visible = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    took <= start && !busy;
    if (!rst && start && !busy) expected_pixels.push_back(project_point(point));
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      point <= '0;
    end else if (!start || took) begin
      if (pending_points.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        start <= 1'b1;
        point <= pending_points.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    wsp_pkg::wsp_pixel_t want;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected result %h", $time, pixel);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (pixel.screen_x !== want.screen_x)
          $display("%0t screen_x expected %h actual %h", $time, want.screen_x, pixel.screen_x);
        if (pixel.screen_y !== want.screen_y)
          $display("%0t screen_y expected %h actual %h", $time, want.screen_y, pixel.screen_y);
        if (pixel.visible !== want.visible)
          $display("%0t visible expected %b actual %b", $time, want.visible, pixel.visible);
        if (pixel !== want) errors++;
      end
    end
  end

  task automatic reg_write(wsp_pkg::wsp_reg_t idx, logic [63:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = wsp_pkg::AddrW'(int'(idx) * 8);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    shadow_regs[idx] = (idx >= wsp_pkg::REG_WIDTH) ? (value & 64'h3FFF) : value;
  endtask

  task automatic drain;
    while (pending_points.size() > 0 || start || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (wsp_pkg::Latency + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q(int lo_sh, int hi_sh);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(lo_sh, hi_sh);
  endfunction

  function automatic wsp_pkg::wsp_point_t rand_point();
    wsp_pkg::wsp_point_t p;
    p.world_x = rand_q(0, 31);
    p.world_y = rand_q(0, 31);
    p.world_z = rand_q(0, 31);
    return p;
  endfunction

  task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    wsp_pkg::wsp_point_t p;
    p.world_x = x;
    p.world_y = y;
    p.world_z = z;
    pending_points.push_back(p);
  endtask

  task automatic plausible_matrix;
    reg_write(wsp_pkg::REG_ROW0_C01, {rand_q(8, 20), rand_q(8, 20)});
    reg_write(wsp_pkg::REG_ROW0_C23, {rand_q(0, 12), rand_q(8, 20)});
    reg_write(wsp_pkg::REG_ROW1_C01, {rand_q(8, 20), rand_q(8, 20)});
    reg_write(wsp_pkg::REG_ROW1_C23, {rand_q(0, 12), rand_q(8, 20)});
    reg_write(wsp_pkg::REG_ROW3_C01, {rand_q(10, 24), rand_q(10, 24)});
    reg_write(wsp_pkg::REG_ROW3_C23,
              {32'($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 20)),
               rand_q(10, 24)});
  endtask

  task automatic random_phase(int n, int idle);
    send_idle_pct = idle;
    repeat (n) pending_points.push_back(rand_point());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    send_idle_pct = 0;
    for (int i = 0; i < wsp_pkg::RegCount; i++) shadow_regs[i] = '0;
    shadow_regs[wsp_pkg::REG_WIDTH] = 64'd1920;
    shadow_regs[wsp_pkg::REG_HEIGHT] = 64'd1080;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset matrix gives w = 0 for every point, so everything is invisible.
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    drain();

    // w follows world_x directly, exercising the visibility threshold.
    reg_write(wsp_pkg::REG_ROW0_C01, {32'h0, 32'h0001_0000});
    reg_write(wsp_pkg::REG_ROW0_C23, {32'h0000_8000, 32'h0});
    reg_write(wsp_pkg::REG_ROW1_C01, {32'h0001_0000, 32'h0});
    reg_write(wsp_pkg::REG_ROW1_C23, {32'hFFFF_8000, 32'h0});
    reg_write(wsp_pkg::REG_ROW3_C01, {32'h0, 32'h0001_0000});
    reg_write(wsp_pkg::REG_ROW3_C23, {32'h0, 32'h0});
    push_point(32'd655, 32'd5, 32'd0);
    push_point(32'd656, 32'd5, 32'd0);
    push_point(32'd657, 32'h7FFF_FFFF, 32'd0);
    push_point(32'h8000_0000, 32'd0, 32'd0);
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_point(32'h0001_0000, 32'hFFFF_0000, 32'h0);
    push_point(32'd0, 32'd0, 32'd0);
    push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    reg_write(wsp_pkg::REG_WIDTH, 64'd1);
    reg_write(wsp_pkg::REG_HEIGHT, 64'd1);
    push_point(32'd656, 32'h7FFF_FFFF, 32'd0);
    push_point(32'h0010_0000, 32'h8000_0000, 32'd0);
    drain();
    reg_write(wsp_pkg::REG_WIDTH, 64'd16383);
    reg_write(wsp_pkg::REG_HEIGHT, 64'd16383);
    push_point(32'd656, 32'h7FFF_FFFF, 32'd0);
    push_point(32'h0010_0000, 32'h8000_0000, 32'd0);
    push_point(32'h7FFF_FFFF, 32'h0000_0001, 32'd0);
    drain();

    // Extreme matrix entries.
    reg_write(wsp_pkg::REG_ROW0_C01, {32'h8000_0000, 32'h7FFF_FFFF});
    reg_write(wsp_pkg::REG_ROW0_C23, {32'h7FFF_FFFF, 32'h8000_0000});
    reg_write(wsp_pkg::REG_ROW1_C01, {32'h7FFF_FFFF, 32'h8000_0000});
    reg_write(wsp_pkg::REG_ROW1_C23, {32'h8000_0000, 32'h7FFF_FFFF});
    reg_write(wsp_pkg::REG_ROW3_C01, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    reg_write(wsp_pkg::REG_ROW3_C23, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_point(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    random_phase(100, 0);

    plausible_matrix();
    reg_write(wsp_pkg::REG_WIDTH, 64'd1920);
    reg_write(wsp_pkg::REG_HEIGHT, 64'd1080);
    random_phase(350, 0);

    plausible_matrix();
    reg_write(wsp_pkg::REG_WIDTH, 64'($urandom_range(1, 16383)));
    reg_write(wsp_pkg::REG_HEIGHT, 64'($urandom_range(1, 16383)));
    random_phase(350, 59);

    plausible_matrix();
    reg_write(wsp_pkg::REG_WIDTH, 64'd16383);
    reg_write(wsp_pkg::REG_HEIGHT, 64'd1);
    random_phase(350, 23);

    reg_write(wsp_pkg::REG_ROW0_C01, {$urandom, $urandom});
    reg_write(wsp_pkg::REG_ROW0_C23, {$urandom, $urandom});
    reg_write(wsp_pkg::REG_ROW1_C01, {$urandom, $urandom});
    reg_write(wsp_pkg::REG_ROW1_C23, {$urandom, $urandom});
    reg_write(wsp_pkg::REG_ROW3_C01, {$urandom, $urandom});
    reg_write(wsp_pkg::REG_ROW3_C23, {$urandom, $urandom});
    reg_write(wsp_pkg::REG_WIDTH, 64'd1);
    reg_write(wsp_pkg::REG_HEIGHT, 64'd16383);
    random_phase(300, 59);

    plausible_matrix();
    reg_write(wsp_pkg::REG_WIDTH, 64'($urandom_range(1, 4096)));
    reg_write(wsp_pkg::REG_HEIGHT, 64'($urandom_range(1, 4096)));
    random_phase(480, 0);

    if (errors == 0) begin
      $display("PASS world_to_screen_projection");
    end else begin
      $display("FAIL world_to_screen_projection");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/wsp_pkg.sv
rtl/wsp_regs.sv
rtl/wsp_clip.sv
rtl/wsp_div.sv
rtl/world_to_screen_projection.sv
tb/tb_world_to_screen_projection.sv
